/* rtl/dgcd_pkg.sv */
package dgcd_pkg;

	localparam int MAX_NODES = 16;
	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int COUNT_W = $clog2(MAX_NODES + 1);
	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] NODE_COUNT_RESET = CFG_W'(16);

	localparam logic REQ_ADD_EDGE = 1'b0;
	localparam logic REQ_CHECK = 1'b1;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	typedef enum logic [1:0] {
		COLOR_UNVISITED = 2'd0,
		COLOR_ON_PATH = 2'd1,
		COLOR_DONE = 2'd2
	} color_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROOT,
		ST_SCAN,
		ST_RESP
	} state_t;

	typedef enum logic [2:0] {
		DP_NOP,
		DP_ACCEPT,
		DP_ROOT_SKIP,
		DP_ROOT_START,
		DP_ADVANCE,
		DP_POP
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic sel_scan;
	} dp_cmd_t;

	typedef struct packed {
		logic is_check;
		logic root_done;
		logic root_visited;
		logic scan_end;
		logic found;
		logic last_level;
	} dp_status_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [COUNT_W-1:0] scan;
	} stack_entry_t;

endpackage

/* rtl/dgcd_req_if.sv */
interface dgcd_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [3:0] from_node;
	logic [3:0] to_node;

	modport source (output valid, output req_type, output from_node, output to_node,
		input ready);
	modport sink (input valid, input req_type, input from_node, input to_node,
		output ready);
endinterface

/* rtl/dgcd_rsp_if.sv */
interface dgcd_rsp_if;
	logic valid;
	logic ready;
	logic status;
	logic cycle_found;

	modport source (output valid, output status, output cycle_found, input ready);
	modport sink (input valid, input status, input cycle_found, output ready);
endinterface

/* rtl/dgcd_cfg_if.sv */
interface dgcd_cfg_if;
	logic valid;
	logic ready;
	logic [4:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/directed_graph_cycle_detector_core.sv */
// Directed graph cycle detector. The graph is held as a 16 by 16 adjacency bit matrix that
// reset clears; the cfg channel sets the number of nodes in use, clamped to 16. An add-edge
// request has its result ready in the cycle after its transfer. A check runs a three-color
// depth-first search that reads one adjacency bit per cycle and stops early when a cycle
// is found. One request is worked at a time; a new request transfers in the same cycle
// the pending result does.
module directed_graph_cycle_detector_core (
	input logic clk,
	input logic arst_n,
	dgcd_cfg_if.sink cfg,
	dgcd_req_if.sink req,
	dgcd_rsp_if.source rsp
);

	dgcd_pkg::dp_cmd_t cmd;
	dgcd_pkg::dp_status_t status;

	assign cfg.ready = 1'b1;

	dgcd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.status(status),
		.cmd(cmd)
	);

	dgcd_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg.valid),
		.cfg_data(cfg.data),
		.req_type(req.req_type),
		.from_node(req.from_node),
		.to_node(req.to_node),
		.cmd(cmd),
		.status(status),
		.result_status(rsp.status),
		.result_cycle(rsp.cycle_found)
	);

endmodule

/* rtl/dgcd_ctrl.sv */
module dgcd_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input dgcd_pkg::dp_status_t status,
	output dgcd_pkg::dp_cmd_t cmd
);

	dgcd_pkg::state_t state_q;
	dgcd_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dgcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op = dgcd_pkg::DP_NOP;
		cmd.sel_scan = 1'b0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			dgcd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = dgcd_pkg::DP_ACCEPT;
					state_d = status.is_check ? dgcd_pkg::ST_ROOT : dgcd_pkg::ST_RESP;
				end
			end
			dgcd_pkg::ST_ROOT: begin
				if (status.root_done) begin
					state_d = dgcd_pkg::ST_RESP;
				end else if (status.root_visited) begin
					cmd.op = dgcd_pkg::DP_ROOT_SKIP;
				end else begin
					cmd.op = dgcd_pkg::DP_ROOT_START;
					state_d = dgcd_pkg::ST_SCAN;
				end
			end
			dgcd_pkg::ST_SCAN: begin
				cmd.sel_scan = 1'b1;
				if (status.scan_end) begin
					cmd.op = dgcd_pkg::DP_POP;
					if (status.last_level) begin
						state_d = dgcd_pkg::ST_ROOT;
					end
				end else begin
					cmd.op = dgcd_pkg::DP_ADVANCE;
					if (status.found) begin
						state_d = dgcd_pkg::ST_RESP;
					end
				end
			end
			dgcd_pkg::ST_RESP: begin
				out_valid = 1'b1;
				in_ready = out_ready;
				if (out_ready) begin
					if (in_valid) begin
						cmd.op = dgcd_pkg::DP_ACCEPT;
						state_d = status.is_check ? dgcd_pkg::ST_ROOT : dgcd_pkg::ST_RESP;
					end else begin
						state_d = dgcd_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = dgcd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/dgcd_datapath.sv */
module dgcd_datapath (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic [dgcd_pkg::CFG_W-1:0] cfg_data,
	input logic req_type,
	input logic [3:0] from_node,
	input logic [3:0] to_node,
	input dgcd_pkg::dp_cmd_t cmd,
	output dgcd_pkg::dp_status_t status,
	output logic result_status,
	output logic result_cycle
);

	localparam int NW = dgcd_pkg::NODE_W;
	localparam int CW = dgcd_pkg::COUNT_W;
	localparam int MN = dgcd_pkg::MAX_NODES;

	logic [dgcd_pkg::CFG_W-1:0] node_count_q;
	logic [MN-1:0] adj_q [MN];
	dgcd_pkg::color_t color_q [MN];
	dgcd_pkg::stack_entry_t stack_q [MN];
	logic [NW-1:0] cur_node_q;
	logic [CW-1:0] cur_j_q;
	logic [CW-1:0] depth_q;
	logic [CW-1:0] root_q;
	logic result_status_q;
	logic result_cycle_q;

	logic [CW-1:0] n_used;
	logic [NW-1:0] color_addr;
	dgcd_pkg::color_t color_rd;
	logic hit;
	logic can_push;
	logic add_reject;
	logic [CW-1:0] depth_m1;
	logic [CW-1:0] depth_m2;

	always_comb begin
		if (32'(node_count_q) > MN) begin
			n_used = CW'(MN);
		end else begin
			n_used = CW'(node_count_q);
		end
	end

	assign color_addr = cmd.sel_scan ? cur_j_q[NW-1:0] : root_q[NW-1:0];
	assign color_rd = color_q[color_addr];
	assign hit = adj_q[cur_node_q][cur_j_q[NW-1:0]];
	assign can_push = depth_q < CW'(MN);
	assign depth_m1 = depth_q - CW'(1);
	assign depth_m2 = depth_q - CW'(2);
	assign add_reject = (CW'(from_node) >= n_used) || (CW'(to_node) >= n_used) ||
		(from_node == to_node);

	assign status.is_check = (req_type == dgcd_pkg::REQ_CHECK);
	assign status.root_done = root_q >= n_used;
	assign status.root_visited = color_rd != dgcd_pkg::COLOR_UNVISITED;
	assign status.scan_end = cur_j_q >= n_used;
	assign status.found = hit && (color_rd == dgcd_pkg::COLOR_ON_PATH);
	assign status.last_level = depth_q == CW'(1);

	assign result_status = result_status_q;
	assign result_cycle = result_cycle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= dgcd_pkg::NODE_COUNT_RESET;
			for (int i = 0; i < MN; i++) begin
				adj_q[i] <= '0;
			end
			depth_q <= '0;
		end else begin
			if (cfg_valid) begin
				node_count_q <= cfg_data;
			end
			case (cmd.op)
				dgcd_pkg::DP_ACCEPT: begin
					if (req_type == dgcd_pkg::REQ_ADD_EDGE) begin
						if (!add_reject) begin
							adj_q[from_node[NW-1:0]][to_node[NW-1:0]] <= 1'b1;
						end
					end else begin
						depth_q <= '0;
					end
				end
				dgcd_pkg::DP_ROOT_START: begin
					depth_q <= CW'(1);
				end
				dgcd_pkg::DP_ADVANCE: begin
					if (hit && (color_rd == dgcd_pkg::COLOR_UNVISITED) && can_push) begin
						depth_q <= depth_q + CW'(1);
					end
				end
				dgcd_pkg::DP_POP: begin
					depth_q <= depth_m1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			dgcd_pkg::DP_ACCEPT: begin
				if (req_type == dgcd_pkg::REQ_ADD_EDGE) begin
					result_status_q <= add_reject ? dgcd_pkg::STATUS_INVALID
						: dgcd_pkg::STATUS_OK;
				end else begin
					result_status_q <= dgcd_pkg::STATUS_OK;
					for (int i = 0; i < MN; i++) begin
						color_q[i] <= dgcd_pkg::COLOR_UNVISITED;
					end
					root_q <= '0;
				end
				result_cycle_q <= 1'b0;
			end
			dgcd_pkg::DP_ROOT_SKIP: begin
				root_q <= root_q + CW'(1);
			end
			dgcd_pkg::DP_ROOT_START: begin
				color_q[root_q[NW-1:0]] <= dgcd_pkg::COLOR_ON_PATH;
				cur_node_q <= root_q[NW-1:0];
				cur_j_q <= '0;
			end
			dgcd_pkg::DP_ADVANCE: begin
				if (hit && (color_rd == dgcd_pkg::COLOR_ON_PATH)) begin
					result_cycle_q <= 1'b1;
				end
				if (hit && (color_rd == dgcd_pkg::COLOR_UNVISITED) && can_push) begin
					color_q[cur_j_q[NW-1:0]] <= dgcd_pkg::COLOR_ON_PATH;
					stack_q[depth_m1[NW-1:0]].node <= cur_node_q;
					stack_q[depth_m1[NW-1:0]].scan <= cur_j_q + CW'(1);
					cur_node_q <= cur_j_q[NW-1:0];
					cur_j_q <= '0;
				end else begin
					cur_j_q <= cur_j_q + CW'(1);
				end
			end
			dgcd_pkg::DP_POP: begin
				color_q[cur_node_q] <= dgcd_pkg::COLOR_DONE;
				if (depth_q == CW'(1)) begin
					root_q <= root_q + CW'(1);
				end else begin
					cur_node_q <= stack_q[depth_m2[NW-1:0]].node;
					cur_j_q <= stack_q[depth_m2[NW-1:0]].scan;
				end
			end
			default: begin
			end
		endcase
	end

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= CW'(MN))
		else $error("search stack depth beyond node capacity");

	a_advance_has_level: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == dgcd_pkg::DP_ADVANCE || cmd.op == dgcd_pkg::DP_POP) |-> depth_q != '0)
		else $error("scan step with an empty search stack");

	a_last_pop_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == dgcd_pkg::DP_POP && depth_q == CW'(1)) |=> depth_q == '0)
		else $error("last pop did not empty the search stack");

	a_check_starts_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == dgcd_pkg::DP_ACCEPT && req_type == dgcd_pkg::REQ_CHECK) |=>
		(result_status_q == dgcd_pkg::STATUS_OK && !result_cycle_q))
		else $error("check result not cleared at start of search");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import dgcd_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 300;
	localparam int MAX_WAIT = 12;

	typedef enum logic [1:0] {
		STEP_REQUEST,
		STEP_SET_COUNT,
		STEP_DRAIN
	} step_kind_t;

	typedef struct packed {
		step_kind_t kind;
		logic req_type;
		logic [NODE_W-1:0] from_node;
		logic [NODE_W-1:0] to_node;
		logic [CFG_W-1:0] count;
	} step_t;

	typedef struct packed {
		logic [31:0] serial;
		logic is_check;
		logic status;
		logic cycle_found;
	} result_t;

	logic clk = 1'b0;
	logic arst_n;

	dgcd_cfg_if cfg_if();
	dgcd_req_if req_if();
	dgcd_rsp_if rsp_if();

	directed_graph_cycle_detector_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.req(req_if),
		.rsp(rsp_if)
	);

	logic [MAX_NODES-1:0] graph_rows [MAX_NODES];
	logic [CFG_W-1:0] node_limit;

	step_t pending_steps [$];
	result_t expected_results [$];

	int items_sent = 0;
	int results_seen = 0;
	int fail_count = 0;
	int checks_sent = 0;
	int cycles_predicted = 0;
	int edges_rejected = 0;
	int count_writes = 0;
	int cycle_count = 0;
	int gap_left = 0;
	int stall_left = 0;
	int quiet_left [2];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function int draw_wait(int side);
		if (quiet_left[side] > 0) begin
			quiet_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			quiet_left[side] = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, MAX_WAIT);
	endfunction

	function int active_nodes();
		return (node_limit > MAX_NODES) ? MAX_NODES : int'(node_limit);
	endfunction

	function automatic logic search_for_cycle();
		color_t color [MAX_NODES];
		int path_node [MAX_NODES];
		int next_col [MAX_NODES];
		int n;
		int depth;
		int lvl;
		int v;
		int j;
		int root;
		int i;
		n = active_nodes();
		for (i = 0; i < MAX_NODES; i++)
			color[i] = COLOR_UNVISITED;
		for (root = 0; root < n; root++) begin
			if (color[root] == COLOR_UNVISITED) begin
				color[root] = COLOR_ON_PATH;
				path_node[0] = root;
				next_col[0] = 0;
				depth = 1;
				while (depth > 0) begin
					lvl = depth - 1;
					v = path_node[lvl];
					j = next_col[lvl];
					if (j >= n) begin
						color[v] = COLOR_DONE;
						depth = lvl;
					end else begin
						next_col[lvl] = j + 1;
						if (graph_rows[v][j]) begin
							if (color[j] == COLOR_ON_PATH)
								return 1'b1;
							if (color[j] == COLOR_UNVISITED && depth < MAX_NODES) begin
								color[j] = COLOR_ON_PATH;
								path_node[depth] = j;
								next_col[depth] = 0;
								depth++;
							end
						end
					end
				end
			end
		end
		return 1'b0;
	endfunction

	task predict_request(logic kind, logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
		result_t want;
		want.serial = items_sent;
		want.is_check = (kind == REQ_CHECK);
		if (kind == REQ_CHECK) begin
			want.status = STATUS_OK;
			want.cycle_found = search_for_cycle();
			checks_sent++;
			if (want.cycle_found)
				cycles_predicted++;
		end else begin
			want.cycle_found = 1'b0;
			if (src >= active_nodes() || dst >= active_nodes() || src == dst) begin
				want.status = STATUS_INVALID;
				edges_rejected++;
			end else begin
				want.status = STATUS_OK;
				graph_rows[src][dst] = 1'b1;
			end
		end
		expected_results.push_back(want);
		items_sent++;
	endtask

	task report_mismatch(string what);
		fail_count++;
		if (fail_count <= 50)
			$display("MISMATCH (%0d): %s", fail_count, what);
	endtask

	task add_edge(int src, int dst);
		step_t step;
		step = '0;
		step.kind = STEP_REQUEST;
		step.req_type = REQ_ADD_EDGE;
		step.from_node = NODE_W'(src);
		step.to_node = NODE_W'(dst);
		pending_steps.push_back(step);
	endtask

	task add_check();
		step_t step;
		step = '0;
		step.kind = STEP_REQUEST;
		step.req_type = REQ_CHECK;
		step.from_node = NODE_W'($urandom_range(0, MAX_NODES - 1));
		step.to_node = NODE_W'($urandom_range(0, MAX_NODES - 1));
		pending_steps.push_back(step);
	endtask

	task add_count(int value);
		step_t step;
		step = '0;
		step.kind = STEP_SET_COUNT;
		step.count = CFG_W'(value);
		pending_steps.push_back(step);
	endtask

	task add_drain();
		step_t step;
		step = '0;
		step.kind = STEP_DRAIN;
		pending_steps.push_back(step);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
				expected_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		logic next_req_valid;
		logic next_cfg_valid;
		step_t step;
		if (arst_n) begin
			next_req_valid = req_if.valid;
			next_cfg_valid = cfg_if.valid;
			if (req_if.valid && req_if.ready) begin
				predict_request(req_if.req_type, req_if.from_node, req_if.to_node);
				next_req_valid = 1'b0;
				gap_left = draw_wait(0);
			end
			if (cfg_if.valid && cfg_if.ready) begin
				node_limit = cfg_if.data;
				count_writes++;
				next_cfg_valid = 1'b0;
				gap_left = draw_wait(0);
			end
			if (!next_req_valid && !next_cfg_valid && pending_steps.size() != 0) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_steps[0].kind == STEP_REQUEST
						|| items_sent == results_seen) begin
					step = pending_steps.pop_front();
					case (step.kind)
					STEP_REQUEST: begin
						req_if.req_type <= step.req_type;
						req_if.from_node <= step.from_node;
						req_if.to_node <= step.to_node;
						next_req_valid = 1'b1;
					end
					STEP_SET_COUNT: begin
						cfg_if.data <= step.count;
						next_cfg_valid = 1'b1;
					end
					default: begin
					end
					endcase
				end
			end
			req_if.valid <= next_req_valid;
			cfg_if.valid <= next_cfg_valid;
		end
	end

	always @(posedge clk) begin
		logic next_ready;
		result_t want;
		if (arst_n) begin
			next_ready = rsp_if.ready;
			if (rsp_if.valid && rsp_if.ready) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					report_mismatch("response transfer with no request pending");
				end else begin
					want = expected_results.pop_front();
					if (rsp_if.status !== want.status)
						report_mismatch($sformatf("request %0d (%s): status %b, expected %b",
							want.serial, want.is_check ? "check" : "add edge",
							rsp_if.status, want.status));
					if (rsp_if.cycle_found !== want.cycle_found)
						report_mismatch($sformatf("request %0d (%s): cycle_found %b, expected %b",
							want.serial, want.is_check ? "check" : "add edge",
							rsp_if.cycle_found, want.cycle_found));
				end
				stall_left = draw_wait(1);
				next_ready = (stall_left == 0);
			end else if (!rsp_if.ready) begin
				if (stall_left != 0)
					stall_left--;
				next_ready = (stall_left == 0);
			end
			rsp_if.ready <= next_ready;
		end
	end

	initial begin
		int count;
		int k;
		int pick;
		int src;
		int dst;
		int phase_idx;
		int i;

		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.req_type = REQ_ADD_EDGE;
		req_if.from_node = '0;
		req_if.to_node = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		rsp_if.ready = 1'b0;
		quiet_left[0] = 0;
		quiet_left[1] = 0;
		node_limit = NODE_COUNT_RESET;
		for (i = 0; i < MAX_NODES; i++)
			graph_rows[i] = '0;

		// Until the final phases of random edges, back edges only ever leave the highest node in
		// use, so lowering the count by one hides every cycle that has been built so far.
		add_check();
		add_edge(0, 15);
		add_edge(15, 15);
		add_edge(0, 0);
		add_edge(14, 15);
		add_check();
		add_edge(15, 14);
		add_check();
		add_edge(15, 0);
		add_count(15);
		add_check();
		add_edge(14, 15);
		add_edge(15, 3);
		add_edge(0, 1);
		add_count(0);
		add_check();
		add_edge(0, 1);
		add_count(1);
		add_check();
		add_edge(0, 0);
		add_count(31);
		add_check();
		add_edge(15, 1);
		add_count(17);
		add_check();
		add_count(16);
		add_check();

		for (count = 15; count >= 2; count--) begin
			add_count(count);
			for (k = 0; k < 38; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 58) begin
					src = $urandom_range(0, count - 2);
					add_edge(src, $urandom_range(src + 1, count - 1));
				end else if (pick < 80) begin
					add_check();
				end else if (pick < 88) begin
					src = $urandom_range(0, MAX_NODES - 1);
					add_edge(src, src);
				end else if (pick < 97) begin
					src = $urandom_range(count, MAX_NODES - 1);
					dst = $urandom_range(0, MAX_NODES - 1);
					if (pick[0])
						add_edge(src, dst);
					else
						add_edge(dst, src);
				end else begin
					add_drain();
				end
			end
			for (k = 0; k < 2; k++) begin
				add_edge(count - 1, $urandom_range(0, count - 2));
				add_check();
			end
		end

		for (phase_idx = 0; phase_idx < 6; phase_idx++) begin
			if (phase_idx == 0)
				add_count(16);
			else
				add_count($urandom_range(0, 31));
			for (k = 0; k < 25; k++) begin
				if ($urandom_range(0, 2) == 0)
					add_check();
				else
					add_edge($urandom_range(0, MAX_NODES - 1), $urandom_range(0, MAX_NODES - 1));
			end
			add_drain();
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_steps.size() != 0 || req_if.valid || cfg_if.valid
				|| items_sent != results_seen)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d expected responses never arrived",
				expected_results.size()));

		$display("Sent %0d requests: %0d cycle checks (%0d expecting a cycle), %0d rejected edges.",
			items_sent, checks_sent, cycles_predicted, edges_rejected);
		$display("Node count written %0d times, values from 0 to 31; %0d mismatches.",
			count_writes, fail_count);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* filelist.f */
rtl/dgcd_pkg.sv
rtl/dgcd_req_if.sv
rtl/dgcd_rsp_if.sv
rtl/dgcd_cfg_if.sv
rtl/dgcd_ctrl.sv
rtl/dgcd_datapath.sv
rtl/directed_graph_cycle_detector_core.sv
tb/testbench.sv
